FILE: hw/rtl/nft_pkg.sv
// nft_pkg: shared constants, state encoding and calendar helpers
// for the friday-the-13th finder; no dependencies
package nft_pkg;

    // number of friday-13th dates reported per start date
    localparam int unsigned RESULT_COUNT = 3;
    localparam int unsigned COUNT_W      = $clog2(RESULT_COUNT + 1);

    localparam logic [4:0] TARGET_DAY = 5'd13;
    localparam logic [2:0] FRIDAY     = 3'd6;
    localparam logic [2:0] SATURDAY   = 3'd7;
    localparam logic [2:0] SUNDAY     = 3'd1;

    localparam logic [3:0] JANUARY   = 4'd1;
    localparam logic [3:0] FEBRUARY  = 4'd2;
    localparam logic [3:0] APRIL     = 4'd4;
    localparam logic [3:0] JUNE      = 4'd6;
    localparam logic [3:0] SEPTEMBER = 4'd9;
    localparam logic [3:0] NOVEMBER  = 4'd11;
    localparam logic [3:0] DECEMBER  = 4'd12;

    localparam logic [4:0] LEAP_FEB_DAYS   = 5'd29;
    localparam logic [4:0] COMMON_FEB_DAYS = 5'd28;
    localparam logic [4:0] SHORT_DAYS      = 5'd30;
    localparam logic [4:0] LONG_DAYS       = 5'd31;

    // leap rule repeats every 400 years; year mod 400 is kept in REM_W bits
    localparam int unsigned YEAR_CYCLE = 400;
    localparam int unsigned CENTURY    = 100;
    localparam int unsigned REM_W      = 9;
    // 400 << 7 is the largest shifted divisor below 2^16
    localparam logic [2:0]  SHIFT_TOP  = 3'd7;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_WALK
    } state_t;

    function automatic logic is_leap(input logic [REM_W-1:0] r400);
        logic div4;
        logic cent;
        begin
            div4 = (r400[1:0] == 2'b00);
            cent = (r400 == REM_W'(CENTURY)) || (r400 == REM_W'(2 * CENTURY))
                || (r400 == REM_W'(3 * CENTURY));
            return (r400 == '0) || (div4 && !cent);
        end
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        begin
            if (m == FEBRUARY)
            begin
                len = leap ? LEAP_FEB_DAYS : COMMON_FEB_DAYS;
            end
            else if ((m == APRIL) || (m == JUNE) || (m == SEPTEMBER) || (m == NOVEMBER))
            begin
                len = SHORT_DAYS;
            end
            else
            begin
                len = LONG_DAYS;
            end
            return len;
        end
    endfunction

    // weekday k days after w, w in 1..7, k below 50
    function automatic logic [2:0] wday_after(input logic [2:0] w, input logic [5:0] k);
        logic [5:0] s;
        begin
            s = 6'(w) - 6'd1 + k;
            if (s >= 6'd28)
            begin
                s = s - 6'd28;
            end
            if (s >= 6'd14)
            begin
                s = s - 6'd14;
            end
            if (s >= 6'd7)
            begin
                s = s - 6'd7;
            end
            return 3'(s + 6'd1);
        end
    endfunction

endpackage

FILE: hw/rtl/next_friday_thirteenth_finder_core.sv
// next_friday_thirteenth_finder_core: top level of the friday-the-13th finder
// depends on nft_pkg
//
// usage:
//   input channel (in_valid / in_stall) takes one beat holding a start date
//   (start_day, start_month, start_year) and its weekday, 1=sunday..7=saturday.
//   output channel (out_valid / out_stall) returns RESULT_COUNT beats, one per
//   friday the 13th on or after the start date, in date order; last_found
//   marks the final beat of the run.
// sequencing:
//   after a beat is taken, year mod 400 is formed by a shared compare-subtract
//   unit, one shifted divisor per cycle, from 400 << 7 down to 400. the walk
//   then jumps from one 13th to the next 13th in one cycle per month, except
//   while a match waits for the output register to free up.
//   in_stall stays high from the accepted beat until the last result is
//   loaded into the output register.
// reset:
//   rst_n clears the sequencer to idle and drops out_valid; no clearing pass.
// backpressure:
//   a result sits in the output register while out_stall is high; the walk
//   holds on the next match until the register frees up. a new start date
//   is taken while the last result of the previous run still waits.
module next_friday_thirteenth_finder_core (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [4:0]  start_day,
    input  logic [3:0]  start_month,
    input  logic [15:0] start_year,
    input  logic [2:0]  start_weekday,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [4:0]  found_day,
    output logic [3:0]  found_month,
    output logic [15:0] found_year,
    output logic        last_found
);

    // sequencer and counters
    nft_pkg::state_t state_reg, state_next;
    logic [2:0]                  sh_reg, sh_next;
    logic [nft_pkg::COUNT_W-1:0] count_reg, count_next;
    logic                        out_valid_reg, out_valid_next;

    // walk date; rem_reg holds the year under reduction, then year mod 400
    logic [4:0]  day_reg, day_next;
    logic [3:0]  month_reg, month_next;
    logic [15:0] year_reg, year_next;
    logic [2:0]  wday_reg, wday_next;
    logic [15:0] rem_reg, rem_next;

    // output register payload
    logic [3:0]  out_month_reg, out_month_next;
    logic [15:0] out_year_reg, out_year_next;
    logic        out_last_reg, out_last_next;

    // datapath
    logic                     out_free;
    logic                     leap;
    logic [4:0]               mlen;
    logic                     is_match;
    logic                     is_last;
    logic                     emit_last;
    logic                     cross_month;
    logic [5:0]               step_k;
    logic [2:0]               wday_step;
    logic [3:0]               month_adv;
    logic [15:0]              year_adv;
    logic [nft_pkg::REM_W-1:0] r400;
    logic [nft_pkg::REM_W-1:0] r400_adv;
    logic [16:0]              divisor;
    logic                     rem_ge;

    assign in_stall    = (state_reg != nft_pkg::ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign found_day   = nft_pkg::TARGET_DAY;
    assign found_month = out_month_reg;
    assign found_year  = out_year_reg;
    assign last_found  = out_last_reg;

    assign out_free = !out_valid_reg || !out_stall;

    // calendar of the current walk month
    assign r400     = rem_reg[nft_pkg::REM_W-1:0];
    assign leap     = nft_pkg::is_leap(r400);
    assign mlen     = nft_pkg::month_len(month_reg, leap);
    assign is_match = (day_reg == nft_pkg::TARGET_DAY) && (wday_reg == nft_pkg::FRIDAY);
    assign is_last  = (count_reg == nft_pkg::COUNT_W'(nft_pkg::RESULT_COUNT - 1));
    assign emit_last = (state_reg == nft_pkg::ST_WALK) && is_match && out_free && is_last;

    // days to the next 13th: same month before the 13th, else next month;
    // a day past the month length counts as the day before day 1 of the next month
    always_comb
    begin
        if (day_reg < nft_pkg::TARGET_DAY)
        begin
            cross_month = 1'b0;
            step_k      = 6'(nft_pkg::TARGET_DAY - day_reg);
        end
        else if (day_reg > mlen)
        begin
            cross_month = 1'b1;
            step_k      = 6'(nft_pkg::TARGET_DAY);
        end
        else
        begin
            cross_month = 1'b1;
            step_k      = 6'(mlen) - 6'(day_reg) + 6'(nft_pkg::TARGET_DAY);
        end
    end

    assign wday_step = nft_pkg::wday_after(wday_reg, step_k);

    // month roll: month 12 and above go to january of the next year
    always_comb
    begin
        if (month_reg >= nft_pkg::DECEMBER)
        begin
            month_adv = nft_pkg::JANUARY;
            year_adv  = year_reg + 16'd1;
            if (year_reg == 16'hFFFF)
            begin
                r400_adv = '0;
            end
            else if (r400 == nft_pkg::REM_W'(nft_pkg::YEAR_CYCLE - 1))
            begin
                r400_adv = '0;
            end
            else
            begin
                r400_adv = r400 + nft_pkg::REM_W'(1);
            end
        end
        else
        begin
            month_adv = month_reg + 4'd1;
            year_adv  = year_reg;
            r400_adv  = r400;
        end
    end

    // shared compare-subtract unit for year mod 400
    assign divisor = 17'(nft_pkg::YEAR_CYCLE) << sh_reg;
    assign rem_ge  = ({1'b0, rem_reg} >= divisor);

    always_comb
    begin
        state_next     = state_reg;
        sh_next        = sh_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        day_next       = day_reg;
        month_next     = month_reg;
        year_next      = year_reg;
        wday_next      = wday_reg;
        rem_next       = rem_reg;
        out_month_next = out_month_reg;
        out_year_next  = out_year_reg;
        out_last_next  = out_last_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            nft_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    day_next   = start_day;
                    month_next = start_month;
                    year_next  = start_year;
                    // weekday zero steps to sunday, just as saturday does
                    wday_next  = (start_weekday == 3'd0) ? nft_pkg::SATURDAY : start_weekday;
                    rem_next   = start_year;
                    sh_next    = nft_pkg::SHIFT_TOP;
                    count_next = '0;
                    state_next = nft_pkg::ST_REDUCE;
                end
            end

            nft_pkg::ST_REDUCE:
            begin
                if (rem_ge)
                begin
                    rem_next = rem_reg - divisor[15:0];
                end
                if (sh_reg == 3'd0)
                begin
                    state_next = nft_pkg::ST_WALK;
                end
                else
                begin
                    sh_next = sh_reg - 3'd1;
                end
            end

            nft_pkg::ST_WALK:
            begin
                if (!is_match || out_free)
                begin
                    if (is_match)
                    begin
                        out_valid_next = 1'b1;
                        out_month_next = month_reg;
                        out_year_next  = year_reg;
                        out_last_next  = is_last;
                        count_next     = count_reg + nft_pkg::COUNT_W'(1);
                    end
                    if (is_match && is_last)
                    begin
                        state_next = nft_pkg::ST_IDLE;
                    end
                    else
                    begin
                        day_next  = nft_pkg::TARGET_DAY;
                        wday_next = wday_step;
                        if (cross_month)
                        begin
                            month_next = month_adv;
                            year_next  = year_adv;
                            rem_next   = 16'(r400_adv);
                        end
                    end
                end
            end

            default:
            begin
                state_next = nft_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nft_pkg::ST_IDLE;
            sh_reg        <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sh_reg        <= sh_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        day_reg       <= day_next;
        month_reg     <= month_next;
        year_reg      <= year_next;
        wday_reg      <= wday_next;
        rem_reg       <= rem_next;
        out_month_reg <= out_month_next;
        out_year_reg  <= out_year_next;
        out_last_reg  <= out_last_next;
    end

`ifndef SYNTHESIS
    // year mod 400 is fully reduced before the walk uses it
    a_rem_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == nft_pkg::ST_WALK) |-> (rem_reg < 16'(nft_pkg::YEAR_CYCLE)))
        else $error("year remainder not reduced during walk");

    // weekday never zero once loaded
    a_wday_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != nft_pkg::ST_IDLE) |-> (wday_reg != 3'd0))
        else $error("walk weekday out of range");

    // result count stays below the run length while walking
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == nft_pkg::ST_WALK)
        |-> (count_reg < nft_pkg::COUNT_W'(nft_pkg::RESULT_COUNT)))
        else $error("result count overrun");

    // the last result ends the run and shows up flagged
    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        emit_last |=> ((state_reg == nft_pkg::ST_IDLE) && out_valid_reg && out_last_reg))
        else $error("last result did not end the run");
`endif

endmodule
